@@ rtl/bbc_pkg.sv @@
`default_nettype none

package bbc_pkg;

   // lexical modes
   typedef enum logic [2:0] {
      MODE_CODE   = 3'd0,
      MODE_SLASH  = 3'd1,
      MODE_SQUOTE = 3'd2,
      MODE_DQUOTE = 3'd3,
      MODE_CMT    = 3'd4,
      MODE_CSTAR  = 3'd5
   } lex_mode_type;

   // bracket codes, as kept on the stack
   typedef logic [1:0] bracket_type;
   localparam bracket_type BR_NONE    = 2'd0;
   localparam bracket_type BR_PAREN   = 2'd1;
   localparam bracket_type BR_BRACE   = 2'd2;
   localparam bracket_type BR_BRACKET = 2'd3;

   // result kinds
   typedef logic [2:0] match_kind_type;
   localparam match_kind_type KIND_NONE    = 3'd0;
   localparam match_kind_type KIND_SQUOTE  = 3'd4;
   localparam match_kind_type KIND_DQUOTE  = 3'd5;
   localparam match_kind_type KIND_COMMENT = 3'd6;

   // characters with a role
   typedef logic [7:0] char_type;
   localparam char_type CH_LPAREN   = 8'h28;
   localparam char_type CH_RPAREN   = 8'h29;
   localparam char_type CH_LBRACE   = 8'h7B;
   localparam char_type CH_RBRACE   = 8'h7D;
   localparam char_type CH_LBRACKET = 8'h5B;
   localparam char_type CH_RBRACKET = 8'h5D;
   localparam char_type CH_SQUOTE   = 8'h27;
   localparam char_type CH_DQUOTE   = 8'h22;
   localparam char_type CH_SLASH    = 8'h2F;
   localparam char_type CH_STAR     = 8'h2A;

   // stack command from the lexer
   typedef struct packed {
      logic        push;
      logic        pop;
      logic        clear;
      bracket_type code;
   } stack_cmd_type;

   // stack status back to the lexer
   typedef struct packed {
      logic        empty;
      logic        single;
      logic        full;
      bracket_type top;
   } stack_stat_type;

   function automatic bracket_type opener_code(input char_type ch);
      bracket_type code;
      case (ch)
         CH_LPAREN:   code = BR_PAREN;
         CH_LBRACE:   code = BR_BRACE;
         CH_LBRACKET: code = BR_BRACKET;
         default:     code = BR_NONE;
      endcase
      return code;
   endfunction

   function automatic bracket_type closer_code(input char_type ch);
      bracket_type code;
      case (ch)
         CH_RPAREN:   code = BR_PAREN;
         CH_RBRACE:   code = BR_BRACE;
         CH_RBRACKET: code = BR_BRACKET;
         default:     code = BR_NONE;
      endcase
      return code;
   endfunction

endpackage

`default_nettype wire

@@ rtl/bbc_req_if.sv @@
`default_nettype none

interface bbc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_in;
   logic       last;

   modport source (output valid, output char_in, output last, input ready);
   modport sink   (input valid, input char_in, input last, output ready);
endinterface

`default_nettype wire

@@ rtl/bbc_rsp_if.sv @@
`default_nettype none

interface bbc_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] match_kind;
   logic       failed;
   logic       text_end;
   logic       balanced;

   modport source (output valid, output match_kind, output failed, output text_end,
                   output balanced, input ready);
   modport sink   (input valid, input match_kind, input failed, input text_end,
                   input balanced, output ready);
endinterface

`default_nettype wire

@@ rtl/bbc_stack.sv @@
`default_nettype none

module bbc_stack #(
   parameter int STACK_DEPTH = 64
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire bbc_pkg::stack_cmd_type  cmd,
   output bbc_pkg::stack_stat_type      stat
);

   localparam int DW = $clog2(STACK_DEPTH + 1);
   localparam int AW = $clog2(STACK_DEPTH);

   logic [DW-1:0]        depth_ff, depth_in;
   bbc_pkg::bracket_type top_ff, top_in;
   bbc_pkg::bracket_type below_ff, below_in;
   bbc_pkg::bracket_type rd_ff;
   bbc_pkg::bracket_type mem [STACK_DEPTH];
   logic [AW-1:0]        wr_addr;
   logic [AW-1:0]        rd_addr;

   // top and the entry under it are cached, memory prefetches the one below that
   always_comb begin
      depth_in = depth_ff;
      top_in   = top_ff;
      below_in = below_ff;
      if (cmd.clear) begin
         depth_in = '0;
      end else if (cmd.push) begin
         depth_in = depth_ff + DW'(1);
         top_in   = cmd.code;
         below_in = top_ff;
      end else if (cmd.pop) begin
         depth_in = depth_ff - DW'(1);
         top_in   = below_ff;
         below_in = rd_ff;
      end
   end

   assign wr_addr = depth_ff[AW-1:0];
   assign rd_addr = AW'(depth_in - DW'(3));

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff <= '0;
      end else begin
         depth_ff <= depth_in;
      end
   end

   always_ff @(posedge clock) begin
      top_ff   <= top_in;
      below_ff <= below_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.push && !cmd.clear) begin
         mem[wr_addr] <= cmd.code;
      end
      rd_ff <= mem[rd_addr];
   end

   assign stat.empty  = (depth_ff == '0);
   assign stat.single = (depth_ff == DW'(1));
   assign stat.full   = (depth_ff == DW'(STACK_DEPTH));
   assign stat.top    = top_ff;

endmodule

`default_nettype wire

@@ rtl/bracket_balance_checker.sv @@
`default_nettype none

// channel   dir  handshake          payload
// req_ch    in   valid / ready      char_in[7:0], last
// rsp_ch    out  valid / ready      match_kind[2:0], failed, text_end, balanced
//
// one result per character, one character per cycle sustained while rsp_ch.ready is held high
// result appears in the cycle after the transfer, held in an output register
// req_ch.ready stays high while the output register is empty or being drained
// synchronous reset clears the lexical mode, stack depth, failure flag and rsp valid
// stack entries live in a memory with top and next-below cached in flops

module bracket_balance_checker #(
   parameter int STACK_DEPTH = 64
) (
   input wire logic   clock,
   input wire logic   reset,
   bbc_req_if.sink    req_ch,
   bbc_rsp_if.source  rsp_ch
);

   // lexer state
   bbc_pkg::lex_mode_type mode_ff, mode_in;
   logic                  fail_ff, fail_in;

   // output register
   logic                    rsp_valid_ff, rsp_valid_in;
   bbc_pkg::match_kind_type rsp_kind_ff;
   logic                    rsp_failed_ff;
   logic                    rsp_end_ff;
   logic                    rsp_bal_ff;

   // per-character decode
   logic                    accept;
   logic                    code_path;
   logic                    fail_set;
   logic                    push;
   logic                    pop;
   logic                    empty_after;
   logic                    balanced;
   bbc_pkg::match_kind_type kind;
   bbc_pkg::bracket_type    op_code;
   bbc_pkg::bracket_type    cl_code;
   bbc_pkg::char_type       ch;
   bbc_pkg::stack_cmd_type  stack_cmd;
   bbc_pkg::stack_stat_type stack_stat;

   // output register frees up when empty or when its result is taken
   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign accept       = req_ch.valid && req_ch.ready;
   assign ch           = req_ch.char_in;
   assign op_code      = bbc_pkg::opener_code(ch);
   assign cl_code      = bbc_pkg::closer_code(ch);

   // lexical mode and bracket handling
   always_comb begin
      mode_in   = mode_ff;
      kind      = bbc_pkg::KIND_NONE;
      code_path = 1'b0;
      fail_set  = 1'b0;
      push      = 1'b0;
      pop       = 1'b0;

      unique case (mode_ff)
         bbc_pkg::MODE_CODE: begin
            code_path = 1'b1;
         end
         bbc_pkg::MODE_SLASH: begin
            // slash followed by star opens a comment, anything else is code
            if (ch == bbc_pkg::CH_STAR) begin
               mode_in = bbc_pkg::MODE_CMT;
            end else begin
               code_path = 1'b1;
            end
         end
         bbc_pkg::MODE_SQUOTE: begin
            if (ch == bbc_pkg::CH_SQUOTE) begin
               mode_in = bbc_pkg::MODE_CODE;
               kind    = bbc_pkg::KIND_SQUOTE;
            end
         end
         bbc_pkg::MODE_DQUOTE: begin
            if (ch == bbc_pkg::CH_DQUOTE) begin
               mode_in = bbc_pkg::MODE_CODE;
               kind    = bbc_pkg::KIND_DQUOTE;
            end
         end
         bbc_pkg::MODE_CMT: begin
            if (ch == bbc_pkg::CH_STAR) begin
               mode_in = bbc_pkg::MODE_CSTAR;
            end
         end
         bbc_pkg::MODE_CSTAR: begin
            // a run of stars keeps waiting for the closing slash
            if (ch == bbc_pkg::CH_SLASH) begin
               mode_in = bbc_pkg::MODE_CODE;
               kind    = bbc_pkg::KIND_COMMENT;
            end else if (ch != bbc_pkg::CH_STAR) begin
               mode_in = bbc_pkg::MODE_CMT;
            end
         end
         default: begin
            code_path = 1'b1;
         end
      endcase

      if (code_path) begin
         mode_in = bbc_pkg::MODE_CODE;
         if (ch == bbc_pkg::CH_SQUOTE) begin
            mode_in = bbc_pkg::MODE_SQUOTE;
         end else if (ch == bbc_pkg::CH_DQUOTE) begin
            mode_in = bbc_pkg::MODE_DQUOTE;
         end else if (ch == bbc_pkg::CH_SLASH) begin
            mode_in = bbc_pkg::MODE_SLASH;
         end else if (op_code != bbc_pkg::BR_NONE) begin
            // overflow flags failure and drops the opener
            if (stack_stat.full) begin
               fail_set = 1'b1;
            end else begin
               push = 1'b1;
            end
         end else if (cl_code != bbc_pkg::BR_NONE) begin
            if (stack_stat.empty) begin
               fail_set = 1'b1;
            end else begin
               // a mismatched closer still pops
               pop = 1'b1;
               if (stack_stat.top != cl_code) begin
                  fail_set = 1'b1;
               end else begin
                  kind = {1'b0, cl_code};
               end
            end
         end
      end
   end

   assign fail_in = fail_ff || fail_set;

   always_comb begin
      if (push) begin
         empty_after = 1'b0;
      end else if (pop) begin
         empty_after = stack_stat.single;
      end else begin
         empty_after = stack_stat.empty;
      end
   end

   // verdict: no failure, no open quote or comment, no open bracket
   assign balanced = req_ch.last && !fail_in && empty_after &&
                     (mode_in == bbc_pkg::MODE_CODE || mode_in == bbc_pkg::MODE_SLASH);

   assign stack_cmd.push  = accept && push;
   assign stack_cmd.pop   = accept && pop;
   assign stack_cmd.clear = accept && req_ch.last;
   assign stack_cmd.code  = op_code;

   bbc_stack #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock (clock),
      .reset (reset),
      .cmd   (stack_cmd),
      .stat  (stack_stat)
   );

   // lexer state, cleared after the last character of a text
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= bbc_pkg::MODE_CODE;
         fail_ff <= 1'b0;
      end else if (accept) begin
         if (req_ch.last) begin
            mode_ff <= bbc_pkg::MODE_CODE;
            fail_ff <= 1'b0;
         end else begin
            mode_ff <= mode_in;
            fail_ff <= fail_in;
         end
      end
   end

   // output register
   always_comb begin
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_kind_ff   <= kind;
         rsp_failed_ff <= fail_in;
         rsp_end_ff    <= req_ch.last;
         rsp_bal_ff    <= balanced;
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.match_kind = rsp_kind_ff;
   assign rsp_ch.failed     = rsp_failed_ff;
   assign rsp_ch.text_end   = rsp_end_ff;
   assign rsp_ch.balanced   = rsp_bal_ff;

endmodule

`default_nettype wire

@@ tb/sv/tb_bracket_balance_checker.sv @@
`default_nettype none

module tb_bracket_balance_checker;

   localparam int          STACK_LIMIT  = 64;      // nesting depth of the instance
   localparam int unsigned IDLE_PCT     = 28;      // share of cycles either side sits idle
   localparam int unsigned DRAIN_CYCLES = 8;       // settle time once nothing is due
   localparam int unsigned CYCLE_LIMIT  = 100000;  // hard stop for a hung run

   // one result per character, as the block reports it
   typedef struct packed {
      bbc_pkg::match_kind_type kind;
      logic                    failed;
      logic                    text_end;
      logic                    balanced;
   } scan_result_type;

   logic clock = 1'b0;
   logic reset;

   bbc_req_if req_ch ();
   bbc_rsp_if rsp_ch ();

   bracket_balance_checker #(
      .STACK_DEPTH(STACK_LIMIT)
   ) DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always #6 clock = ~clock;

   // results still owed by the block, oldest first
   scan_result_type   scan_results_due[$];
   // characters of the text about to be sent
   bbc_pkg::char_type text_buf[$];

   int unsigned mismatch_count = 0;
   int unsigned sent_items     = 0;
   int unsigned cycle_count    = 0;
   int unsigned hold_cycles    = 0;   // receiver hold-off still to run, in cycles
   bit          idle_on        = 1'b1;

   // ------------------------------------------------------------------
   // scanner: lexical mode, bracket stack and sticky failure of the text
   // ------------------------------------------------------------------
   bbc_pkg::lex_mode_type scan_mode  = bbc_pkg::MODE_CODE;
   bbc_pkg::bracket_type  nest_stack [STACK_LIMIT];
   int unsigned           nest_depth = 0;
   logic                  fail_seen  = 1'b0;

   function automatic void scan_push(input bbc_pkg::bracket_type code);
      // a full stack refuses the opener and marks the text as failed
      if (nest_depth >= STACK_LIMIT) begin
         fail_seen = 1'b1;
      end else begin
         nest_stack[nest_depth] = code;
         nest_depth++;
      end
   endfunction

   function automatic bbc_pkg::match_kind_type scan_pop(input bbc_pkg::bracket_type code);
      // closer on an empty stack: underflow
      if (nest_depth == 0) begin
         fail_seen = 1'b1;
         return bbc_pkg::KIND_NONE;
      end
      nest_depth--;
      // wrong kind of closer: the top is still consumed
      if (nest_stack[nest_depth] != code) begin
         fail_seen = 1'b1;
         return bbc_pkg::KIND_NONE;
      end
      // paren, brace and bracket report as their own stack code
      return bbc_pkg::match_kind_type'(code);
   endfunction

   function automatic bbc_pkg::match_kind_type scan_code(input bbc_pkg::char_type ch);
      bbc_pkg::match_kind_type kind;
      kind = bbc_pkg::KIND_NONE;
      case (ch)
         bbc_pkg::CH_SQUOTE:   scan_mode = bbc_pkg::MODE_SQUOTE;
         bbc_pkg::CH_DQUOTE:   scan_mode = bbc_pkg::MODE_DQUOTE;
         bbc_pkg::CH_SLASH:    scan_mode = bbc_pkg::MODE_SLASH;
         bbc_pkg::CH_LPAREN:   scan_push(bbc_pkg::BR_PAREN);
         bbc_pkg::CH_LBRACE:   scan_push(bbc_pkg::BR_BRACE);
         bbc_pkg::CH_LBRACKET: scan_push(bbc_pkg::BR_BRACKET);
         bbc_pkg::CH_RPAREN:   kind = scan_pop(bbc_pkg::BR_PAREN);
         bbc_pkg::CH_RBRACE:   kind = scan_pop(bbc_pkg::BR_BRACE);
         bbc_pkg::CH_RBRACKET: kind = scan_pop(bbc_pkg::BR_BRACKET);
         default:              ;
      endcase
      return kind;
   endfunction

   function automatic scan_result_type scan_char(input bbc_pkg::char_type ch,
                                                 input logic fin);
      scan_result_type res;
      res.kind     = bbc_pkg::KIND_NONE;
      res.balanced = 1'b0;
      case (scan_mode)
         bbc_pkg::MODE_SLASH: begin
            // slash then star opens a comment, anything else is plain code
            if (ch == bbc_pkg::CH_STAR) begin
               scan_mode = bbc_pkg::MODE_CMT;
            end else begin
               scan_mode = bbc_pkg::MODE_CODE;
               res.kind  = scan_code(ch);
            end
         end
         bbc_pkg::MODE_SQUOTE: begin
            if (ch == bbc_pkg::CH_SQUOTE) begin
               scan_mode = bbc_pkg::MODE_CODE;
               res.kind  = bbc_pkg::KIND_SQUOTE;
            end
         end
         bbc_pkg::MODE_DQUOTE: begin
            if (ch == bbc_pkg::CH_DQUOTE) begin
               scan_mode = bbc_pkg::MODE_CODE;
               res.kind  = bbc_pkg::KIND_DQUOTE;
            end
         end
         bbc_pkg::MODE_CMT: begin
            if (ch == bbc_pkg::CH_STAR) begin
               scan_mode = bbc_pkg::MODE_CSTAR;
            end
         end
         bbc_pkg::MODE_CSTAR: begin
            // a run of stars keeps waiting for the slash
            if (ch == bbc_pkg::CH_SLASH) begin
               scan_mode = bbc_pkg::MODE_CODE;
               res.kind  = bbc_pkg::KIND_COMMENT;
            end else if (ch != bbc_pkg::CH_STAR) begin
               scan_mode = bbc_pkg::MODE_CMT;
            end
         end
         default: begin
            scan_mode = bbc_pkg::MODE_CODE;
            res.kind  = scan_code(ch);
         end
      endcase
      res.failed   = fail_seen;
      res.text_end = fin;
      if (fin) begin
         // a pending lone slash is harmless, open quotes and comments are not
         res.balanced = !fail_seen && nest_depth == 0 &&
                        (scan_mode == bbc_pkg::MODE_CODE ||
                         scan_mode == bbc_pkg::MODE_SLASH);
         scan_mode  = bbc_pkg::MODE_CODE;
         nest_depth = 0;
         fail_seen  = 1'b0;
      end
      return res;
   endfunction

   // ------------------------------------------------------------------
   // text generation
   // ------------------------------------------------------------------
   function automatic bbc_pkg::char_type bracket_char(input bbc_pkg::bracket_type code,
                                                      input bit closing);
      bbc_pkg::char_type ch;
      case (code)
         bbc_pkg::BR_PAREN: ch = closing ? bbc_pkg::CH_RPAREN : bbc_pkg::CH_LPAREN;
         bbc_pkg::BR_BRACE: ch = closing ? bbc_pkg::CH_RBRACE : bbc_pkg::CH_LBRACE;
         default:           ch = closing ? bbc_pkg::CH_RBRACKET : bbc_pkg::CH_LBRACKET;
      endcase
      return ch;
   endfunction

   // mostly well-formed text with random content; noise_pct of the steps
   // drop in an arbitrary byte, which may break the structure
   function automatic void build_text(input int unsigned len, input int unsigned nest_cap,
                                      input int unsigned noise_pct);
      bbc_pkg::bracket_type open_q[$];
      int unsigned          roll;
      int unsigned          body;
      bbc_pkg::char_type    quote;
      bbc_pkg::char_type    ch;
      text_buf.delete();
      while (text_buf.size() < len) begin
         roll = $urandom_range(99);
         if (roll < noise_pct) begin
            text_buf.push_back(bbc_pkg::char_type'($urandom_range(255)));
         end else if (roll < noise_pct + 30 && open_q.size() < nest_cap) begin
            open_q.push_back(bbc_pkg::bracket_type'(
               $urandom_range(bbc_pkg::BR_BRACKET, bbc_pkg::BR_PAREN)));
            text_buf.push_back(bracket_char(open_q[$], 1'b0));
         end else if (roll < noise_pct + 55 && open_q.size() > 0) begin
            text_buf.push_back(bracket_char(open_q.pop_back(), 1'b1));
         end else if (roll < noise_pct + 65) begin
            // quoted run: brackets inside are skipped
            quote = $urandom_range(1) ? bbc_pkg::CH_SQUOTE : bbc_pkg::CH_DQUOTE;
            text_buf.push_back(quote);
            repeat ($urandom_range(4)) begin
               do ch = bbc_pkg::char_type'($urandom_range(255)); while (ch == quote);
               text_buf.push_back(ch);
            end
            text_buf.push_back(quote);
         end else if (roll < noise_pct + 72) begin
            // comment, body never closes it early but may start with a slash
            text_buf.push_back(bbc_pkg::CH_SLASH);
            text_buf.push_back(bbc_pkg::CH_STAR);
            body = $urandom_range(5);
            for (int unsigned n = 0; n < body; n++) begin
               ch = bbc_pkg::char_type'($urandom_range(255));
               if (n > 0 && ch == bbc_pkg::CH_SLASH && text_buf[$] == bbc_pkg::CH_STAR) begin
                  ch = bbc_pkg::CH_LPAREN;
               end
               text_buf.push_back(ch);
            end
            text_buf.push_back(bbc_pkg::CH_STAR);
            text_buf.push_back(bbc_pkg::CH_SLASH);
         end else begin
            do ch = bbc_pkg::char_type'($urandom_range(255));
            while (ch inside {bbc_pkg::CH_LPAREN, bbc_pkg::CH_RPAREN, bbc_pkg::CH_LBRACE,
                              bbc_pkg::CH_RBRACE, bbc_pkg::CH_LBRACKET,
                              bbc_pkg::CH_RBRACKET, bbc_pkg::CH_SQUOTE,
                              bbc_pkg::CH_DQUOTE, bbc_pkg::CH_SLASH});
            text_buf.push_back(ch);
         end
      end
      // most texts are closed off, a few are left with brackets open
      if ($urandom_range(9) != 0) begin
         while (open_q.size() > 0) text_buf.push_back(bracket_char(open_q.pop_back(), 1'b1));
      end
   endfunction

   // ------------------------------------------------------------------
   // request side: one transfer per call, entered and left at a falling edge
   // ------------------------------------------------------------------
   task automatic send_char(input bbc_pkg::char_type ch, input logic fin);
      while (idle_on && $urandom_range(99) < IDLE_PCT) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.char_in <= ch;
      req_ch.last    <= fin;
      @(posedge clock);
      while (req_ch.ready !== 1'b1) @(posedge clock);
      // transfer taken at this edge, so the block owes one result for it
      scan_results_due.push_back(scan_char(ch, fin));
      sent_items++;
      @(negedge clock);
   endtask

   task automatic send_text();
      foreach (text_buf[i]) send_char(text_buf[i], i == text_buf.size() - 1);
   endtask

   task automatic send_string(input string s);
      text_buf.delete();
      for (int i = 0; i < s.len(); i++) text_buf.push_back(bbc_pkg::char_type'(s[i]));
      send_text();
   endtask

   // ------------------------------------------------------------------
   // result side: ready pattern, with an optional long hold-off
   // ------------------------------------------------------------------
   initial begin : drive_rsp_ready
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_ch.ready <= 1'b0;
         end else if (idle_on && $urandom_range(99) < IDLE_PCT) begin
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // every result transfer is matched against the oldest one owed
   always @(posedge clock) begin : check_results
      scan_result_type due;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (scan_results_due.size() == 0) begin
            $error("result transfer with no character pending");
            mismatch_count++;
         end else begin
            due = scan_results_due.pop_front();
            if (rsp_ch.match_kind !== due.kind) begin
               $error("match_kind: expected %0d, got %0d", due.kind, rsp_ch.match_kind);
               mismatch_count++;
            end
            if (rsp_ch.failed !== due.failed) begin
               $error("failed: expected %0b, got %0b", due.failed, rsp_ch.failed);
               mismatch_count++;
            end
            if (rsp_ch.text_end !== due.text_end) begin
               $error("text_end: expected %0b, got %0b", due.text_end, rsp_ch.text_end);
               mismatch_count++;
            end
            if (rsp_ch.balanced !== due.balanced) begin
               $error("balanced: expected %0b, got %0b", due.balanced, rsp_ch.balanced);
               mismatch_count++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------

   // all three pairs nested, with the lowest and highest byte as plain text
   task automatic test_pairs_and_extremes();
      text_buf = '{bbc_pkg::CH_LPAREN, 8'h00, bbc_pkg::CH_LBRACE, bbc_pkg::CH_LBRACKET,
                   8'hFF, bbc_pkg::CH_RBRACKET, bbc_pkg::CH_RBRACE, bbc_pkg::CH_RPAREN};
      send_text();
   endtask

   // brackets in quotes are skipped, the opening star does not end a comment,
   // a double slash starts nothing and a lone slash at the end is harmless
   task automatic test_quotes_and_comments();
      send_string("'('\"]\"/*/**///");
   endtask

   // underflow, mismatch, pairs still reported after failing,
   // then texts ending inside a quote and inside a comment
   task automatic test_failures();
      send_string("](}[]");
      send_string("\"a");
      send_string("/*");
   endtask

   // exactly full stack unwinds cleanly; one opener more overflows
   task automatic test_stack_limits();
      bbc_pkg::bracket_type nest_q[$];
      bbc_pkg::bracket_type code;
      for (int extra = 0; extra < 2; extra++) begin
         text_buf.delete();
         nest_q.delete();
         repeat (STACK_LIMIT + extra) begin
            code = bbc_pkg::bracket_type'(
               $urandom_range(bbc_pkg::BR_BRACKET, bbc_pkg::BR_PAREN));
            nest_q.push_back(code);
            text_buf.push_back(bracket_char(code, 1'b0));
         end
         // the refused opener never reaches the stack
         if (extra != 0) begin
            void'(nest_q.pop_back());
         end
         while (nest_q.size() > 0) text_buf.push_back(bracket_char(nest_q.pop_back(), 1'b1));
         send_text();
      end
   endtask

   task automatic test_random_texts(input int unsigned item_goal);
      int unsigned goal;
      int unsigned noise;
      goal = sent_items + item_goal;
      while (sent_items < goal) begin
         noise = ($urandom_range(4) == 0) ? 40 : 6;
         // now and then a long text that nests deep
         if ($urandom_range(15) == 0) begin
            build_text($urandom_range(100, 40), STACK_LIMIT, 3);
         end else begin
            build_text($urandom_range(24, 1), 6, noise);
         end
         send_text();
      end
   endtask

   // both sides always willing: one transfer per cycle
   task automatic test_back_to_back();
      idle_on = 1'b0;
      test_random_texts(50);
      idle_on = 1'b1;
   endtask

   // receiver holds off while the sender keeps offering, so the input stalls
   task automatic test_output_stall();
      idle_on = 1'b0;
      req_ch.valid <= 1'b0;
      @(posedge clock);
      hold_cycles = 60;
      @(negedge clock);
      build_text(40, 8, 5);
      send_text();
      idle_on = 1'b1;
   endtask

   initial begin
      reset          = 1'b1;
      req_ch.valid   = 1'b0;
      req_ch.char_in = '0;
      req_ch.last    = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_pairs_and_extremes();
      test_quotes_and_comments();
      test_failures();
      test_stack_limits();
      test_back_to_back();
      test_output_stall();
      test_random_texts(60);

      req_ch.valid <= 1'b0;
      while (scan_results_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
      if (mismatch_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

`default_nettype wire
